FILE: rtl/core/lfq_pkg.sv
package lfq_pkg;

    // Store geometry and field widths.
    localparam int NODE_COUNT    = 16;
    localparam int VALUE_WIDTH   = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(NODE_COUNT);
    localparam int OCC_W         = $clog2(NODE_COUNT + 1);

    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODE_COUNT - 1);
    localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(NODE_COUNT);

    // Request codes carried in req_type.
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lfq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rsp_slot_free;
    } lfq_status_t;

    // Link that an entry holds after reset: the next entry, wrapping at the end.
    function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == LAST_NODE)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/core/lfq_if.sv
interface lfq_req_if;
    import lfq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [PAYLOAD_WIDTH-1:0] data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface lfq_rsp_if;
    import lfq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [PAYLOAD_WIDTH-1:0] data_out;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output ok, output data_out, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input ok, input data_out, input is_empty,
                    input is_full, output ready);
endinterface

FILE: rtl/core/lfq_ctrl.sv
module lfq_ctrl
    import lfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  lfq_status_t status,
    output lfq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Requests are taken only while no other transaction is in flight.
    assign req_ready = (state_reg == ST_IDLE);

    // Command decode.
    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && req_valid;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.commit  = (state_reg == ST_COMMIT) && status.rsp_slot_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.rsp_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/lfq_dpath.sv
module lfq_dpath
    import lfq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfq_cmd_t                 cmd,
    output lfq_status_t              status,
    input  logic                     req_type,
    input  logic [PAYLOAD_WIDTH-1:0] data_in,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic                     rsp_ok,
    output logic [PAYLOAD_WIDTH-1:0] rsp_data_out,
    output logic                     rsp_is_empty,
    output logic                     rsp_is_full
);

    // Node store. Values have no reset; links carry a valid bit per entry so
    // that an unwritten entry reads as its reset link.
    logic [VALUE_WIDTH-1:0] value_mem [NODE_COUNT];
    logic [IDX_W-1:0]       link_mem  [NODE_COUNT];
    logic [NODE_COUNT-1:0]  link_valid_reg;

    // Pointers and count.
    logic [IDX_W-1:0] head_reg,      head_next;
    logic [IDX_W-1:0] tail_reg,      tail_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [OCC_W-1:0] occ_reg,       occ_next;

    // Captured request.
    logic                   req_deq_reg;
    logic [VALUE_WIDTH-1:0] req_value_reg;

    // Registered read port results.
    logic [VALUE_WIDTH-1:0] value_rd_reg;
    logic [IDX_W-1:0]       link_rd_reg;
    logic                   link_rd_valid_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       link_eff;

    // Response register.
    logic                     rsp_valid_reg;
    logic                     rsp_ok_reg;
    logic [PAYLOAD_WIDTH-1:0] rsp_data_reg;
    logic                     rsp_empty_reg;
    logic                     rsp_full_reg;

    // Commit results.
    logic                   ok;
    logic [VALUE_WIDTH-1:0] result;
    logic                   value_we;
    logic                   link_we;
    logic [IDX_W-1:0]       link_waddr;
    logic [IDX_W-1:0]       link_wdata;

    assign status.rsp_slot_free = !rsp_valid_reg || rsp_ready;

    // A dequeue walks from the head, an enqueue from the free list head.
    assign rd_addr  = req_deq_reg ? head_reg : free_head_reg;
    assign link_eff = link_rd_valid_reg ? link_rd_reg : reset_link(rd_addr_reg);

    // Pointer update for the captured request.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        occ_next       = occ_reg;
        ok             = 1'b0;
        result         = '0;
        value_we       = 1'b0;
        link_we        = 1'b0;
        link_waddr     = tail_reg;
        link_wdata     = free_head_reg;
        if (req_deq_reg == REQ_ENQUEUE)
        begin
            if (occ_reg != FULL_OCC)
            begin
                ok             = 1'b1;
                value_we       = 1'b1;
                free_head_next = link_eff;
                tail_next      = free_head_reg;
                occ_next       = occ_reg + 1'b1;
                if (occ_reg == '0)
                begin
                    head_next = free_head_reg;
                end
                else
                begin
                    link_we = 1'b1;
                end
            end
        end
        else
        begin
            if (occ_reg != '0)
            begin
                ok             = 1'b1;
                result         = value_rd_reg;
                link_we        = 1'b1;
                link_waddr     = head_reg;
                head_next      = link_eff;
                free_head_next = head_reg;
                occ_next       = occ_reg - 1'b1;
                if (occ_reg == OCC_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
        end
    end

    // Node store write and read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && value_we)
        begin
            value_mem[free_head_reg] <= req_value_reg;
        end
        if (cmd.commit && link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.lookup)
        begin
            value_rd_reg <= value_mem[rd_addr];
            link_rd_reg  <= link_mem[rd_addr];
        end
    end

    // Request capture and read-side bookkeeping; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_deq_reg   <= req_type;
            req_value_reg <= VALUE_WIDTH'(data_in);
        end
        if (cmd.lookup)
        begin
            link_rd_valid_reg <= link_valid_reg[rd_addr];
            rd_addr_reg       <= rd_addr;
        end
        if (cmd.commit)
        begin
            rsp_ok_reg    <= ok;
            rsp_data_reg  <= PAYLOAD_WIDTH'(result);
            rsp_empty_reg <= (occ_next == '0);
            rsp_full_reg  <= (occ_next == FULL_OCC);
        end
    end

    // Control state: pointers, count, link valid bits and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            free_head_reg  <= '0;
            occ_reg        <= '0;
            link_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                free_head_reg <= free_head_next;
                occ_reg       <= occ_next;
                if (link_we)
                begin
                    link_valid_reg[link_waddr] <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_ok       = rsp_ok_reg;
    assign rsp_data_out = rsp_data_reg;
    assign rsp_is_empty = rsp_empty_reg;
    assign rsp_is_full  = rsp_full_reg;

endmodule

FILE: rtl/core/linked_fifo_with_free_list_core.sv
// Linked-list FIFO with a free list, kept in a node store of NODE_COUNT nodes.
// Request channel (req): req_type selects enqueue of data_in or dequeue of the
// head value. Response channel (rsp): one transaction per request, carrying ok,
// the dequeued value (zero unless a dequeue succeeds) and the empty and full
// flags as they stand after the request.
// Each request passes through three steps: capture, a registered read of the
// node store at the head or free list head, and a commit that writes the store
// and updates the pointers and response register. One request is in flight
// at a time, so a new request is not taken until the last one has committed.
// The response sits in an output register; a request may be accepted while
// it waits. If the receiver stalls, the commit of the next request holds
// until the output register frees, and no further request is accepted.
// Reset empties the queue and links every node to the next one, with the last
// wrapping to the first; the link valid bits are cleared at once, so no
// clearing pass is needed and a request may be sent in the first cycle.
module linked_fifo_with_free_list_core
    import lfq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lfq_req_if.sink   req,
    lfq_rsp_if.source rsp
);

    lfq_cmd_t    cmd;
    lfq_status_t status;

    // Sequencer.
    lfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Node store, pointers and response register.
    lfq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req.req_type),
        .data_in      (req.data_in),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_ok       (rsp.ok),
        .rsp_data_out (rsp.data_out),
        .rsp_is_empty (rsp.is_empty),
        .rsp_is_full  (rsp.is_full)
    );

endmodule
